>>> src/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros used by the checker file
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, ignored while in reset
`define ASSERT_IMPLIES(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, ignored while in reset
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

// next-cycle implication that also holds across reset
`define ASSERT_NEXT_ALWAYS(label, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

>>> src/nlp_pkg.sv
// ----------------------------------------------------------------------------
// nlp_pkg
// shared types and constants of the next permutation pipeline
// ----------------------------------------------------------------------------
package nlp_pkg;

    // field geometry of the word
    localparam int NUM_FIELDS  = 8;
    localparam int ELEM_W      = 4;
    localparam int LEN_W       = 4;
    localparam int IDX_W       = $clog2(NUM_FIELDS);
    localparam int MAX_LEN_DEF = 8;

    // packed stream widths, padded to whole bytes
    localparam int IN_BITS     = LEN_W + NUM_FIELDS * ELEM_W;
    localparam int IN_TDATA_W  = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_BITS    = NUM_FIELDS * ELEM_W;
    localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

    typedef logic [ELEM_W-1:0]         elem_t;
    typedef elem_t [NUM_FIELDS-1:0]    elem_vec_t;

    // incoming word
    typedef struct packed {
        logic [LEN_W-1:0] len;
        elem_vec_t        elems;
    } item_t;

    // after length clamp and ascent detection
    typedef struct packed {
        logic [LEN_W-1:0]      len;
        elem_vec_t             elems;
        logic [NUM_FIELDS-1:0] asc;
    } prep_t;

    // after pivot search
    typedef struct packed {
        logic [LEN_W-1:0] len;
        elem_vec_t        elems;
        logic             found;
        logic [IDX_W-1:0] piv;
        elem_t            piv_val;
    } pivot_t;

    // after swap, with start of the reversed suffix
    typedef struct packed {
        logic [LEN_W-1:0] len;
        elem_vec_t        elems;
        logic [LEN_W-1:0] lo;
    } swap_t;

endpackage

>>> src/nlp_prep.sv
// ----------------------------------------------------------------------------
// nlp_prep
// stage one: clamps the length, clears unused positions, marks ascents
// ----------------------------------------------------------------------------
module nlp_prep #(
    parameter int MAX_LEN = nlp_pkg::MAX_LEN_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  nlp_pkg::item_t in_data,
    output logic           out_valid,
    input  logic           out_ready,
    output nlp_pkg::prep_t out_data
);

    logic           valid_reg;
    nlp_pkg::prep_t data_reg;
    nlp_pkg::prep_t data_next;
    logic [nlp_pkg::LEN_W-1:0] n;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    // clamp, mask and compare neighbours
    always_comb
    begin
        n = (in_data.len > nlp_pkg::LEN_W'(MAX_LEN)) ? nlp_pkg::LEN_W'(MAX_LEN)
                                                     : in_data.len;
        data_next.len = n;
        for (int k = 0; k < nlp_pkg::NUM_FIELDS; k++)
        begin
            data_next.elems[k] = (nlp_pkg::LEN_W'(k) < n) ? in_data.elems[k]
                                                          : '0;
        end
        data_next.asc[0] = 1'b0;
        for (int k = 1; k < nlp_pkg::NUM_FIELDS; k++)
        begin
            data_next.asc[k] = (nlp_pkg::LEN_W'(k) < n) &&
                               (data_next.elems[k-1] < data_next.elems[k]);
        end
    end

    // stage valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    // stage payload
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            data_reg <= data_next;
        end
    end

endmodule

>>> src/nlp_pivot.sv
// ----------------------------------------------------------------------------
// nlp_pivot
// stage two: finds the rightmost ascent and picks the pivot value
// ----------------------------------------------------------------------------
module nlp_pivot (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  nlp_pkg::prep_t  in_data,
    output logic            out_valid,
    input  logic            out_ready,
    output nlp_pkg::pivot_t out_data
);

    logic            valid_reg;
    nlp_pkg::pivot_t data_reg;
    nlp_pkg::pivot_t data_next;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    // priority search, the last ascent seen wins
    always_comb
    begin
        data_next.len   = in_data.len;
        data_next.elems = in_data.elems;
        data_next.found = 1'b0;
        data_next.piv   = '0;
        for (int k = 1; k < nlp_pkg::NUM_FIELDS; k++)
        begin
            if (in_data.asc[k])
            begin
                data_next.found = 1'b1;
                data_next.piv   = nlp_pkg::IDX_W'(k - 1);
            end
        end
        data_next.piv_val = in_data.elems[data_next.piv];
    end

    // stage valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    // stage payload
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            data_reg <= data_next;
        end
    end

endmodule

>>> src/nlp_swap.sv
// ----------------------------------------------------------------------------
// nlp_swap
// stage three: finds the rightmost larger element and swaps it with the pivot
// ----------------------------------------------------------------------------
module nlp_swap (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  nlp_pkg::pivot_t in_data,
    output logic            out_valid,
    input  logic            out_ready,
    output nlp_pkg::swap_t  out_data
);

    logic                      valid_reg;
    nlp_pkg::swap_t            data_reg;
    nlp_pkg::swap_t            data_next;
    logic [nlp_pkg::IDX_W-1:0] j;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    // successor search and exchange
    always_comb
    begin
        j = in_data.piv;
        for (int k = 1; k < nlp_pkg::NUM_FIELDS; k++)
        begin
            if ((nlp_pkg::IDX_W'(k) > in_data.piv) &&
                (nlp_pkg::LEN_W'(k) < in_data.len) &&
                (in_data.elems[k] > in_data.piv_val))
            begin
                j = nlp_pkg::IDX_W'(k);
            end
        end
        data_next.len   = in_data.len;
        data_next.elems = in_data.elems;
        data_next.lo    = '0;
        if (in_data.found)
        begin
            data_next.elems[in_data.piv] = in_data.elems[j];
            data_next.elems[j]           = in_data.piv_val;
            data_next.lo = nlp_pkg::LEN_W'(in_data.piv) + nlp_pkg::LEN_W'(1);
        end
    end

    // stage valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    // stage payload
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            data_reg <= data_next;
        end
    end

endmodule

>>> src/nlp_reverse.sv
// ----------------------------------------------------------------------------
// nlp_reverse
// stage four: reverses the suffix and holds the output word
// ----------------------------------------------------------------------------
module nlp_reverse (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  nlp_pkg::swap_t     in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output nlp_pkg::elem_vec_t out_data
);

    logic                      valid_reg;
    nlp_pkg::elem_vec_t        data_reg;
    nlp_pkg::elem_vec_t        data_next;
    logic [nlp_pkg::LEN_W-1:0] idx;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    // mirror positions lo .. len-1
    always_comb
    begin
        idx = '0;
        for (int k = 0; k < nlp_pkg::NUM_FIELDS; k++)
        begin
            idx = in_data.lo + in_data.len - nlp_pkg::LEN_W'(1) - nlp_pkg::LEN_W'(k);
            if ((nlp_pkg::LEN_W'(k) >= in_data.lo) && (nlp_pkg::LEN_W'(k) < in_data.len))
            begin
                data_next[k] = in_data.elems[idx[nlp_pkg::IDX_W-1:0]];
            end
            else
            begin
                data_next[k] = in_data.elems[k];
            end
        end
    end

    // output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    // output payload
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            data_reg <= data_next;
        end
    end

endmodule

>>> src/next_lexicographic_permutation.sv
// ----------------------------------------------------------------------------
// next_lexicographic_permutation
// returns the lexicographic successor of a permutation, wrapping to identity
// ----------------------------------------------------------------------------
// usage
//   the slave stream carries one permutation per word: the length and up to
//   eight 4-bit values; the master stream returns the successor, with the
//   positions at or beyond the length set to zero. after the descending
//   permutation the identity follows.
//   four register stages: clamp and ascent marks, pivot search, swap with
//   the rightmost larger value, suffix reversal into the output register.
//   m_axis_tvalid rises once the word has passed through the prep, pivot,
//   swap and reverse registers in turn; one word is accepted every
//   cycle while the master side takes them.
//   each stage has its own valid bit and moves when the stage after it is
//   empty or moving, so bubbles are squeezed out when the receiver stalls;
//   with all four stages full and m_axis_tready low, s_axis_tready drops
//   and every word is held in place.
//   reset empties the pipeline; no word is presented until one is accepted.
// ----------------------------------------------------------------------------
module next_lexicographic_permutation #(
    parameter int MAX_LEN = nlp_pkg::MAX_LEN_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // length, element_0 .. element_7, zero pad
    input  logic [nlp_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // next_0 .. next_7
    output logic [nlp_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

    nlp_pkg::item_t     in_item;
    nlp_pkg::prep_t     prep_data;
    nlp_pkg::pivot_t    pivot_data;
    nlp_pkg::swap_t     swap_data;
    nlp_pkg::elem_vec_t out_elems;
    logic               prep_valid, prep_ready;
    logic               pivot_valid, pivot_ready;
    logic               swap_valid, swap_ready;

    // unpack the input word
    always_comb
    begin
        in_item.len = s_axis_tdata[nlp_pkg::LEN_W-1:0];
        for (int k = 0; k < nlp_pkg::NUM_FIELDS; k++)
        begin
            in_item.elems[k] = s_axis_tdata[nlp_pkg::LEN_W + k * nlp_pkg::ELEM_W +:
                                            nlp_pkg::ELEM_W];
        end
    end

    nlp_prep #(
        .MAX_LEN (MAX_LEN)
    ) u_prep (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_data   (in_item),
        .out_valid (prep_valid),
        .out_ready (prep_ready),
        .out_data  (prep_data)
    );

    nlp_pivot u_pivot (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (prep_valid),
        .in_ready  (prep_ready),
        .in_data   (prep_data),
        .out_valid (pivot_valid),
        .out_ready (pivot_ready),
        .out_data  (pivot_data)
    );

    nlp_swap u_swap (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (pivot_valid),
        .in_ready  (pivot_ready),
        .in_data   (pivot_data),
        .out_valid (swap_valid),
        .out_ready (swap_ready),
        .out_data  (swap_data)
    );

    nlp_reverse u_reverse (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (swap_valid),
        .in_ready  (swap_ready),
        .in_data   (swap_data),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (out_elems)
    );

    // pack the output word
    assign m_axis_tdata = nlp_pkg::OUT_TDATA_W'(out_elems);

endmodule

>>> src/nlp_checker.sv
// ----------------------------------------------------------------------------
// nlp_checker
// port-level checks of the next permutation block
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module nlp_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            s_axis_tvalid,
    input logic                            s_axis_tready,
    input logic [nlp_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [nlp_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

    // a stalled word stays presented
    `ASSERT_NEXT(a_out_hold_valid, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)

    // a stalled word keeps its value
    `ASSERT_NEXT(a_out_hold_data, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata))

    // back-pressure only while a word is presented on the output
    `ASSERT_IMPLIES(a_ready_low_full, !s_axis_tready, m_axis_tvalid)

    // reset leaves nothing on the output
    `ASSERT_NEXT_ALWAYS(a_reset_empty, !rst_n, !m_axis_tvalid)

endmodule

bind next_lexicographic_permutation nlp_checker u_nlp_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
